[sv/psg_tone_noise_generator_unit_defines.svh]
// Assertion macros for the PSG tone/noise generator top level.
// Expects clk and rst_n in the scope of use.
`ifndef PSG_TONE_NOISE_GENERATOR_UNIT_DEFINES_SVH
`define PSG_TONE_NOISE_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define PSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/psgtn_pkg.sv]
// Shared types and constants for the PSG tone/noise generator.
// No dependencies.
`default_nettype none

package psgtn_pkg;

  // Request operation codes
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } psgtn_op_t;

  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned LFSR_W   = 16;

  localparam logic [1:0] CH_NOISE = 2'd3;

  // Noise rate selects
  localparam logic [1:0] RATE_FAST = 2'd0;
  localparam logic [1:0] RATE_MID  = 2'd1;
  localparam logic [1:0] RATE_SLOW = 2'd2;
  localparam logic [1:0] RATE_TONE = 2'd3;

  localparam logic [PERIOD_W-1:0] NOISE_PER_FAST = 10'h020;
  localparam logic [PERIOD_W-1:0] NOISE_PER_MID  = 10'h040;
  localparam logic [PERIOD_W-1:0] NOISE_PER_SLOW = 10'h080;
  localparam logic [PERIOD_W-1:0] NOISE_PER_DFLT = 10'h010;
  localparam logic [LFSR_W-1:0]   LFSR_SEED      = 16'h8000;
  localparam logic [3:0]          ATTEN_SILENT   = 4'hF;

  // Per-tone control from the register decode
  typedef struct packed {
    logic       tick;
    logic       wr_low;
    logic       wr_high;
    logic [5:0] data;
  } psgtn_tone_ctl_t;

  // Noise control from the register decode
  typedef struct packed {
    logic       tick;
    logic       reseed;
    logic [2:0] mode;
  } psgtn_noise_ctl_t;

endpackage

`default_nettype wire

[sv/psgtn_tone_ch.sv]
// One square-wave tone channel: period register, down counter, polarity.
// Depends on psgtn_pkg.
`default_nettype none

module psgtn_tone_ch (
  input  logic                      clk,
  input  logic                      rst_n,
  input  psgtn_pkg::psgtn_tone_ctl_t ctl,
  output logic [9:0]                period,
  output logic                      high
);
  import psgtn_pkg::*;

  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [PERIOD_W-1:0] count_r, count_nxt;
  logic                pol_r, pol_nxt;

  // Period writes and tick countdown
  always_comb begin
    period_nxt = period_r;
    count_nxt  = count_r;
    pol_nxt    = pol_r;
    if (ctl.wr_low) begin
      period_nxt[3:0] = ctl.data[3:0];
    end
    if (ctl.wr_high) begin
      period_nxt[9:4] = ctl.data;
    end
    if (ctl.tick && (period_r != '0)) begin
      if (count_r <= 10'd1) begin
        count_nxt = period_r;
        pol_nxt   = ~pol_r;
      end else begin
        count_nxt = count_r - 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      count_r  <= '0;
      pol_r    <= 1'b1;
    end else begin
      period_r <= period_nxt;
      count_r  <= count_nxt;
      pol_r    <= pol_nxt;
    end
  end

  assign period = period_r;
  assign high   = pol_r;

endmodule

`default_nettype wire

[sv/psgtn_noise_ch.sv]
// Noise channel: rate select, down counter and 16-bit shift register.
// Depends on psgtn_pkg.
`default_nettype none

module psgtn_noise_ch (
  input  logic                       clk,
  input  logic                       rst_n,
  input  psgtn_pkg::psgtn_noise_ctl_t ctl,
  input  logic [9:0]                 tone_c_period,
  output logic                       high
);
  import psgtn_pkg::*;

  logic [2:0]          mode_r, mode_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [PERIOD_W-1:0] count_r, count_nxt;
  logic [LFSR_W-1:0]   lfsr_r, lfsr_nxt;
  logic                pol_r, pol_nxt;
  logic                fb;
  logic [PERIOD_W-1:0] rate_period;

  // Period picked by a rate select
  always_comb begin
    unique case (ctl.mode[1:0])
      RATE_FAST: rate_period = NOISE_PER_FAST;
      RATE_MID:  rate_period = NOISE_PER_MID;
      RATE_SLOW: rate_period = NOISE_PER_SLOW;
      RATE_TONE: rate_period = tone_c_period;
      default:   rate_period = tone_c_period;
    endcase
  end

  // Feedback: white mode mixes in tap 3
  assign fb = mode_r[2] ? (lfsr_r[0] ^ lfsr_r[3]) : lfsr_r[0];

  // Reseed on mode write, shift on count expiry
  always_comb begin
    mode_nxt   = mode_r;
    period_nxt = period_r;
    count_nxt  = count_r;
    lfsr_nxt   = lfsr_r;
    pol_nxt    = pol_r;
    if (ctl.reseed) begin
      mode_nxt   = ctl.mode;
      lfsr_nxt   = LFSR_SEED;
      period_nxt = rate_period;
    end
    if (ctl.tick) begin
      if (count_r > 10'd1) begin
        count_nxt = count_r - 10'd1;
      end else begin
        count_nxt = (period_r != '0) ? period_r : NOISE_PER_DFLT;
        lfsr_nxt  = {fb, lfsr_r[LFSR_W-1:1]};
        pol_nxt   = lfsr_r[1];
      end
      // Follow tone C after the tick in tone-rate mode
      if (mode_r[1:0] == RATE_TONE) begin
        period_nxt = tone_c_period;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      period_r <= '0;
      count_r  <= '0;
      lfsr_r   <= LFSR_SEED;
      pol_r    <= 1'b1;
    end else begin
      mode_r   <= mode_nxt;
      period_r <= period_nxt;
      count_r  <= count_nxt;
      lfsr_r   <= lfsr_nxt;
      pol_r    <= pol_nxt;
    end
  end

  assign high = pol_r;

endmodule

`default_nettype wire

[sv/psg_tone_noise_generator_unit.sv]
// Four-channel sound generator: three square tones and one LFSR noise channel.
// Each request is a register write byte or one generator tick.
// A request is registered on acceptance and applied from the input register once
// the result slot is free or being taken, after which one result carries the
// four polarities and attenuations. One request per cycle is sustained while the
// result is not stalled; the path runs through the input register and the
// channel state registers, which double as the result register. A stalled
// result holds the channel state.
// Depends on psgtn_pkg, psgtn_tone_ch, psgtn_noise_ch and the defines header.
`default_nettype none

`include "psg_tone_noise_generator_unit_defines.svh"

module psg_tone_noise_generator_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_operation,
  input  logic [7:0] in_write_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_tone_a_high,
  output logic       out_tone_b_high,
  output logic       out_tone_c_high,
  output logic       out_noise_high,
  output logic [3:0] out_tone_a_atten,
  output logic [3:0] out_tone_b_atten,
  output logic [3:0] out_tone_c_atten,
  output logic [3:0] out_noise_atten
);
  import psgtn_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  psgtn_op_t  s1_op_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r, out_valid_nxt;
  logic       adv;
  logic       fire_wr;
  logic       fire_tick;

  logic [1:0] lat_ch_r, lat_ch_nxt;
  logic       lat_vol_r, lat_vol_nxt;
  logic [3:0] atten_r [4];
  logic       is_latch;
  logic [1:0] eff_ch;
  logic       eff_vol;

  psgtn_tone_ctl_t  tone_ctl [3];
  psgtn_noise_ctl_t noise_ctl;
  logic [9:0]       tone_period [3];
  logic [2:0]       tone_high;

  // Advance when the result slot is free or being taken
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !adv;
  assign fire_wr   = s1_valid_r && adv && (s1_op_r == OP_WRITE);
  assign fire_tick = s1_valid_r && adv && (s1_op_r == OP_TICK);

  // Input register
  always_comb begin
    s1_valid_nxt = in_stall ? s1_valid_r : in_valid;
    out_valid_nxt = adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r   <= psgtn_op_t'(in_operation);
      s1_byte_r <= in_write_byte;
    end
  end

  // Decode: a latch byte sets channel and target, a data byte reuses them
  assign is_latch = s1_byte_r[7];
  assign eff_ch   = is_latch ? s1_byte_r[6:5] : lat_ch_r;
  assign eff_vol  = is_latch ? s1_byte_r[4] : lat_vol_r;

  always_comb begin
    lat_ch_nxt  = lat_ch_r;
    lat_vol_nxt = lat_vol_r;
    if (fire_wr && is_latch) begin
      lat_ch_nxt  = s1_byte_r[6:5];
      lat_vol_nxt = s1_byte_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_ch_r  <= '0;
      lat_vol_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        atten_r[i] <= ATTEN_SILENT;
      end
    end else begin
      lat_ch_r  <= lat_ch_nxt;
      lat_vol_r <= lat_vol_nxt;
      if (fire_wr && eff_vol) begin
        atten_r[eff_ch] <= s1_byte_r[3:0];
      end
    end
  end

  // Per-channel control
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tone_ctl[i].tick    = fire_tick;
      tone_ctl[i].wr_low  = fire_wr && !eff_vol && is_latch && (eff_ch == 2'(i));
      tone_ctl[i].wr_high = fire_wr && !eff_vol && !is_latch && (eff_ch == 2'(i));
      tone_ctl[i].data    = s1_byte_r[5:0];
    end
    noise_ctl.tick   = fire_tick;
    noise_ctl.reseed = fire_wr && is_latch && !eff_vol && (eff_ch == CH_NOISE);
    noise_ctl.mode   = s1_byte_r[2:0];
  end

  // Channels
  for (genvar g = 0; g < 3; g++) begin : g_tone
    psgtn_tone_ch u_tone (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (tone_ctl[g]),
      .period (tone_period[g]),
      .high   (tone_high[g])
    );
  end

  psgtn_noise_ch u_noise (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (noise_ctl),
    .tone_c_period (tone_period[2]),
    .high          (out_noise_high)
  );

  // Result fields straight from the channel state
  assign out_valid        = out_valid_r;
  assign out_tone_a_high  = tone_high[0];
  assign out_tone_b_high  = tone_high[1];
  assign out_tone_c_high  = tone_high[2];
  assign out_tone_a_atten = atten_r[0];
  assign out_tone_b_atten = atten_r[1];
  assign out_tone_c_atten = atten_r[2];
  assign out_noise_atten  = atten_r[3];

  // Checks
  `PSG_ASSERT_NOW(a_stall_needs_req, in_stall, s1_valid_r && out_valid_r,
    "input stalled without a pending request")
  `PSG_ASSERT_NEXT(a_write_keeps_pol, fire_wr,
    $stable({tone_high, out_noise_high}), "register write changed a polarity")
  `PSG_ASSERT_NEXT(a_atten_a_write, fire_wr && eff_vol && (eff_ch == 2'd0),
    out_tone_a_atten == $past(s1_byte_r[3:0]), "tone A attenuation not written")

endmodule

`default_nettype wire

[verif/psg_tone_noise_generator_unit_tb.sv]
// Testbench for psg_tone_noise_generator_unit: queued write and tick requests are driven
// with random bursts and gaps. Every result is checked against a cycle-free model of the
// tone and noise channels. Depends on psgtn_pkg and the unit itself.
`default_nettype none

module psg_tone_noise_generator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psgtn_pkg::*;

  // One result: four polarities and four attenuation codes
  typedef struct packed {
    logic       tone_a_high;
    logic       tone_b_high;
    logic       tone_c_high;
    logic       noise_high;
    logic [3:0] tone_a_atten;
    logic [3:0] tone_b_atten;
    logic [3:0] tone_c_atten;
    logic [3:0] noise_atten;
  } psg_levels_t;

  // One queued request; wait_idle holds it back until no result is outstanding
  typedef struct packed {
    psgtn_op_t  op;
    logic [7:0] wbyte;
    logic       wait_idle;
  } psg_req_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_operation = 1'b0;
  logic [7:0] in_write_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_tone_a_high;
  logic       out_tone_b_high;
  logic       out_tone_c_high;
  logic       out_noise_high;
  logic [3:0] out_tone_a_atten;
  logic [3:0] out_tone_b_atten;
  logic [3:0] out_tone_c_atten;
  logic [3:0] out_noise_atten;

  psg_req_t    pending_reqs[$];
  psg_levels_t expected_levels[$];
  logic        hold_next = 1'b0;
  logic        req_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned error_cnt = 0;
  logic [15:0] stall_pat = 16'h0000;
  logic [6:0]  stall_tick = 7'd0;

  // Generator state as seen from outside
  logic [PERIOD_W-1:0] tone_per [3];
  logic [PERIOD_W-1:0] tone_cnt [3];
  logic                tone_pol [3];
  logic [3:0]          ch_atten [4];
  logic [2:0]          nz_mode;
  logic [PERIOD_W-1:0] nz_per;
  logic [PERIOD_W-1:0] nz_cnt;
  logic [LFSR_W-1:0]   nz_shift;
  logic                nz_pol;
  logic [1:0]          sel_ch;
  logic                sel_vol;

  psg_tone_noise_generator_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_write_byte    (in_write_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tone_a_high  (out_tone_a_high),
    .out_tone_b_high  (out_tone_b_high),
    .out_tone_c_high  (out_tone_c_high),
    .out_noise_high   (out_noise_high),
    .out_tone_a_atten (out_tone_a_atten),
    .out_tone_b_atten (out_tone_b_atten),
    .out_tone_c_atten (out_tone_c_atten),
    .out_noise_atten  (out_noise_atten)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one request to the generator state and return the levels it leaves behind
  function automatic psg_levels_t step_generator(input psgtn_op_t op, input logic [7:0] b);
    logic        fb;
    psg_levels_t lv;
    if (op == OP_WRITE) begin
      if (b[7]) begin
        // Latch byte: select channel and register, load the low bits
        sel_ch  = b[6:5];
        sel_vol = b[4];
        if (sel_vol) begin
          ch_atten[sel_ch] = b[3:0];
        end else if (sel_ch != CH_NOISE) begin
          tone_per[sel_ch][3:0] = b[3:0];
        end else begin
          // Noise control: reseed, count and polarity untouched
          nz_mode  = b[2:0];
          nz_shift = LFSR_SEED;
          case (b[1:0])
            RATE_FAST: nz_per = NOISE_PER_FAST;
            RATE_MID:  nz_per = NOISE_PER_MID;
            RATE_SLOW: nz_per = NOISE_PER_SLOW;
            default:   nz_per = tone_per[2];
          endcase
        end
      end else begin
        // Data byte: volume or period high bits; dropped when noise period is latched
        if (sel_vol) begin
          ch_atten[sel_ch] = b[3:0];
        end else if (sel_ch != CH_NOISE) begin
          tone_per[sel_ch][9:4] = b[5:0];
        end
      end
    end else begin
      // Advance the tones; a zero period holds the channel still
      for (int k = 0; k < 3; k++) begin
        if (tone_per[k] != '0) begin
          if (tone_cnt[k] <= 1) begin
            tone_cnt[k] = tone_per[k];
            tone_pol[k] = ~tone_pol[k];
          end else begin
            tone_cnt[k] = tone_cnt[k] - 1'b1;
          end
        end
      end
      // Advance the noise counter, shift on expiry
      if (nz_cnt > 1) begin
        nz_cnt = nz_cnt - 1'b1;
      end else begin
        nz_cnt   = (nz_per != '0) ? nz_per : NOISE_PER_DFLT;
        fb       = nz_mode[2] ? (nz_shift[0] ^ nz_shift[3]) : nz_shift[0];
        nz_shift = {fb, nz_shift[LFSR_W-1:1]};
        nz_pol   = nz_shift[0];
      end
      // Tone 2 rate reaches the noise channel only after the tick
      if (nz_mode[1:0] == RATE_TONE) nz_per = tone_per[2];
    end
    lv = {tone_pol[0], tone_pol[1], tone_pol[2], nz_pol,
          ch_atten[0], ch_atten[1], ch_atten[2], ch_atten[3]};
    return lv;
  endfunction

  function automatic string fmt_levels(input psg_levels_t lv);
    return $sformatf("pol a%b b%b c%b n%b atten a%h b%h c%h n%h",
                     lv.tone_a_high, lv.tone_b_high, lv.tone_c_high, lv.noise_high,
                     lv.tone_a_atten, lv.tone_b_atten, lv.tone_c_atten, lv.noise_atten);
  endfunction

  task automatic flag_error(input string msg);
    error_cnt++;
    if (error_cnt <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic push_req(input psgtn_op_t op, input logic [7:0] b);
    psg_req_t r;
    r.op        = op;
    r.wbyte     = b;
    r.wait_idle = hold_next;
    pending_reqs.push_back(r);
    hold_next = 1'b0;
  endtask

  // Present requests in bursts; hold the payload until it is taken
  always @(negedge clk) begin : drive_requests
    logic     drive_valid;
    psg_req_t nxt;
    drive_valid = in_valid;
    if (rst_n) begin
      if (req_taken) drive_valid = 1'b0;
      if (!drive_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].wait_idle && expected_levels.size() != 0)) begin
          nxt = pending_reqs.pop_front();
          in_operation  <= nxt.op;
          in_write_byte <= nxt.wbyte;
          drive_valid = 1'b1;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
    in_valid <= drive_valid;
  end

  // Stall results on a random pattern renewed each time the 7-bit tick counter wraps; bit 0 stays clear
  always @(negedge clk) begin : pace_results
    if (stall_tick == '0) begin
      stall_pat = ($urandom_range(0, 3) == 0) ? 16'h0000 : (16'($urandom) & 16'hFFFE);
    end
    out_stall <= stall_pat[stall_tick[3:0]];
    stall_tick = stall_tick + 1'b1;
  end

  // Check each taken result, then predict for each taken request
  always @(posedge clk) begin : check_levels
    psg_levels_t seen;
    psg_levels_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen = {out_tone_a_high, out_tone_b_high, out_tone_c_high, out_noise_high,
                out_tone_a_atten, out_tone_b_atten, out_tone_c_atten, out_noise_atten};
        if (expected_levels.size() == 0) begin
          flag_error($sformatf("result with nothing outstanding: %s", fmt_levels(seen)));
        end else begin
          want = expected_levels.pop_front();
          if (seen !== want)
            flag_error($sformatf("mismatch: expected %s, got %s",
                                 fmt_levels(want), fmt_levels(seen)));
        end
      end
      if (in_valid && !in_stall)
        expected_levels.push_back(step_generator(psgtn_op_t'(in_operation), in_write_byte));
      req_taken <= in_valid && !in_stall;
    end else begin
      req_taken <= 1'b0;
    end
  end

  initial begin : run_test
    int unsigned pick;
    int unsigned next_hold;
    logic [1:0]  ch;

    // Reset values of the generator
    for (int k = 0; k < 3; k++) begin
      tone_per[k] = '0;
      tone_cnt[k] = '0;
      tone_pol[k] = 1'b1;
    end
    for (int k = 0; k < 4; k++) ch_atten[k] = ATTEN_SILENT;
    nz_mode  = '0;
    nz_per   = '0;
    nz_cnt   = '0;
    nz_shift = LFSR_SEED;
    nz_pol   = 1'b1;
    sel_ch   = '0;
    sel_vol  = 1'b0;

    // Directed: ticks from reset, volumes, period extremes, noise modes
    push_req(OP_TICK, 8'hFF);
    push_req(OP_TICK, 8'h00);
    push_req(OP_WRITE, 8'h90);
    push_req(OP_WRITE, 8'h3A);
    push_req(OP_WRITE, 8'hBF);
    push_req(OP_WRITE, 8'hD5);
    push_req(OP_WRITE, 8'hF0);
    push_req(OP_WRITE, 8'h7F);
    push_req(OP_WRITE, 8'h40);
    push_req(OP_WRITE, 8'h81);
    push_req(OP_WRITE, 8'h00);
    push_req(OP_WRITE, 8'hAF);
    push_req(OP_WRITE, 8'h3F);
    push_req(OP_WRITE, 8'hCE);
    push_req(OP_WRITE, 8'h00);
    // Tone-rate noise, then a data byte that noise period ignores
    push_req(OP_WRITE, 8'hE3);
    push_req(OP_WRITE, 8'h2A);
    push_req(OP_TICK, 8'h55);
    push_req(OP_TICK, 8'hAA);
    // Tone 2 change in tone-rate mode lands a tick late
    push_req(OP_WRITE, 8'hC2);
    push_req(OP_TICK, 8'h00);
    push_req(OP_TICK, 8'h00);
    push_req(OP_WRITE, 8'hE4);
    push_req(OP_WRITE, 8'hEF);
    push_req(OP_TICK, 8'h80);
    hold_next = 1'b1;

    // Random: mostly ticks and well-formed write sequences, some raw bytes
    next_hold = 250;
    while (pending_reqs.size() < 925) begin
      if (pending_reqs.size() >= next_hold) begin
        hold_next = 1'b1;
        next_hold += 300;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        repeat ($urandom_range(1, 8)) push_req(OP_TICK, 8'($urandom));
      end else if (pick < 72) begin
        ch = 2'($urandom_range(0, 2));
        push_req(OP_WRITE, {1'b1, ch, 1'b0, 4'($urandom)});
        if ($urandom_range(0, 4) != 0)
          push_req(OP_WRITE, {1'b0, 1'($urandom),
                              ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'd0});
      end else if (pick < 84) begin
        push_req(OP_WRITE, {1'b1, 2'($urandom), 1'b1, 4'($urandom)});
        if ($urandom_range(0, 2) == 0) push_req(OP_WRITE, {1'b0, 7'($urandom)});
      end else if (pick < 92) begin
        push_req(OP_WRITE, {3'b111, 1'b0, 4'($urandom)});
        if ($urandom_range(0, 3) == 0) push_req(OP_WRITE, {1'b0, 7'($urandom)});
      end else begin
        push_req(OP_WRITE, 8'($urandom));
      end
    end

    // Hold reset, then release
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: all requests taken, all results back, then settle
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
